[rtl/mfcn_pkg.sv]
// Package for the stereo multitap feedback comb: sizes, register codes,
// reciprocal table for division by the tap number, and shared structs.
// No dependencies; RTL files use scoped names, the testbench imports it.
`default_nettype none

package mfcn_pkg;

	// Delay memory and tap sizing (depth is a power of two)
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int TAP_COUNT   = 15;
	localparam int TAP_W       = $clog2(TAP_COUNT + 1);

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int PERIOD_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_PERIOD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN   = 2'd3;

	// Register values after reset
	localparam logic [PERIOD_W-1:0]      RST_LEFT_PERIOD   = 16'd100;
	localparam logic [PERIOD_W-1:0]      RST_RIGHT_PERIOD  = 16'd100;
	localparam logic signed [GAIN_W-1:0] RST_HARMONIC_GAIN = 16'sd4096;
	localparam logic signed [GAIN_W-1:0] RST_OUTPUT_GAIN   = 16'sd4096;

	// Reciprocals ceil(2^36 / t) for t = 1..64: floor(n / t) equals
	// (n * RCP_TABLE[t-1]) >> 36 for every n up to 2^30.
	localparam int RCP_SHIFT   = 36;
	localparam int RCP_W       = RCP_SHIFT + 1;
	localparam int RCP_LO_W    = 19;
	localparam int RCP_HI_W    = RCP_W - RCP_LO_W;
	localparam int RCP_ENTRIES = 64;
	localparam int RCP_IDX_W   = $clog2(RCP_ENTRIES);

	localparam logic [RCP_W-1:0] RCP_NUM = RCP_W'((64'd1 << RCP_SHIFT) - 64'd1);

	localparam logic [RCP_W-1:0] RCP_TABLE [RCP_ENTRIES] = '{
		RCP_NUM / 1 + 1,  RCP_NUM / 2 + 1,  RCP_NUM / 3 + 1,  RCP_NUM / 4 + 1,
		RCP_NUM / 5 + 1,  RCP_NUM / 6 + 1,  RCP_NUM / 7 + 1,  RCP_NUM / 8 + 1,
		RCP_NUM / 9 + 1,  RCP_NUM / 10 + 1, RCP_NUM / 11 + 1, RCP_NUM / 12 + 1,
		RCP_NUM / 13 + 1, RCP_NUM / 14 + 1, RCP_NUM / 15 + 1, RCP_NUM / 16 + 1,
		RCP_NUM / 17 + 1, RCP_NUM / 18 + 1, RCP_NUM / 19 + 1, RCP_NUM / 20 + 1,
		RCP_NUM / 21 + 1, RCP_NUM / 22 + 1, RCP_NUM / 23 + 1, RCP_NUM / 24 + 1,
		RCP_NUM / 25 + 1, RCP_NUM / 26 + 1, RCP_NUM / 27 + 1, RCP_NUM / 28 + 1,
		RCP_NUM / 29 + 1, RCP_NUM / 30 + 1, RCP_NUM / 31 + 1, RCP_NUM / 32 + 1,
		RCP_NUM / 33 + 1, RCP_NUM / 34 + 1, RCP_NUM / 35 + 1, RCP_NUM / 36 + 1,
		RCP_NUM / 37 + 1, RCP_NUM / 38 + 1, RCP_NUM / 39 + 1, RCP_NUM / 40 + 1,
		RCP_NUM / 41 + 1, RCP_NUM / 42 + 1, RCP_NUM / 43 + 1, RCP_NUM / 44 + 1,
		RCP_NUM / 45 + 1, RCP_NUM / 46 + 1, RCP_NUM / 47 + 1, RCP_NUM / 48 + 1,
		RCP_NUM / 49 + 1, RCP_NUM / 50 + 1, RCP_NUM / 51 + 1, RCP_NUM / 52 + 1,
		RCP_NUM / 53 + 1, RCP_NUM / 54 + 1, RCP_NUM / 55 + 1, RCP_NUM / 56 + 1,
		RCP_NUM / 57 + 1, RCP_NUM / 58 + 1, RCP_NUM / 59 + 1, RCP_NUM / 60 + 1,
		RCP_NUM / 61 + 1, RCP_NUM / 62 + 1, RCP_NUM / 63 + 1, RCP_NUM / 64 + 1
	};

	// Control from the sequencer to the datapath
	typedef struct packed {
		logic              load;     // excitation beat taken, preload accumulators
		logic              issue;    // start one tap read
		logic              scale;    // multiply sums by output gain
		logic              round;    // round and saturate
		logic              fbmul;    // multiply by feedback gain
		logic              commit;   // write feedback, advance, present result
		logic [TAP_W-1:0]  tap;      // tap number being issued
		logic [ADDR_W-1:0] wp;       // write position
		logic              wrapped;  // every entry written at least once
	} ctl_t;

	// Status into the sequencer
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic pipe_idle;
	} seq_stat_t;

	// One tap read request per channel
	typedef struct packed {
		logic              v;
		logic [ADDR_W-1:0] addr;
		logic              hit;      // entry was written since reset
		logic [TAP_W-1:0]  t;
	} tap_t;

endpackage

`default_nettype wire

[rtl/mfcn_ifs.sv]
// Valid/ready channel interfaces for excitation and result beats.
// Depends on mfcn_pkg for the sample width.
`default_nettype none

interface mfcn_noise_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mfcn_pkg::SAMPLE_W-1:0]  noise_left;
	logic signed [mfcn_pkg::SAMPLE_W-1:0]  noise_right;

	modport source (output valid, output noise_left, output noise_right, input ready);
	modport sink (input valid, input noise_left, input noise_right, output ready);
	modport monitor (input valid, input noise_left, input noise_right, input ready);
endinterface

interface mfcn_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mfcn_pkg::SAMPLE_W-1:0]  out_left;
	logic signed [mfcn_pkg::SAMPLE_W-1:0]  out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
	modport monitor (input valid, input out_left, input out_right, input ready);
endinterface

`default_nettype wire

[rtl/mfcn_seq.sv]
// Microcoded sequencer: control ROM, step counter, tap counter, write position.
// Depends on mfcn_pkg (ctl_t, seq_stat_t, sizes).
`default_nettype none

module mfcn_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mfcn_pkg::seq_stat_t stat,
	output logic                     in_ready,
	output mfcn_pkg::ctl_t           ctl
);

	typedef logic [2:0] step_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_LAST_TAP,
		COND_PIPE_IDLE,
		COND_OUT_FREE
	} cond_t;

	// On a true condition go to jmp, otherwise stay on the same step
	typedef struct packed {
		logic  in_rdy;
		logic  issue;
		logic  scale;
		logic  round;
		logic  fbmul;
		logic  commit;
		cond_t cond;
		step_t jmp;
	} ucode_t;

	localparam int    UC_DEPTH    = 8;
	localparam step_t ST_WAIT_IN  = 3'd0;
	localparam step_t ST_TAP      = 3'd1;
	localparam step_t ST_DRAIN    = 3'd2;
	localparam step_t ST_SCALE    = 3'd3;
	localparam step_t ST_ROUND    = 3'd4;
	localparam step_t ST_FBMUL    = 3'd5;
	localparam step_t ST_COMMIT   = 3'd6;
	localparam step_t ST_SPARE    = 3'd7;

	localparam ucode_t UCODE [UC_DEPTH] = '{
		'{in_rdy: 1'b1, issue: 1'b0, scale: 1'b0, round: 1'b0, fbmul: 1'b0,
			commit: 1'b0, cond: COND_IN_VALID, jmp: ST_TAP},
		'{in_rdy: 1'b0, issue: 1'b1, scale: 1'b0, round: 1'b0, fbmul: 1'b0,
			commit: 1'b0, cond: COND_LAST_TAP, jmp: ST_DRAIN},
		'{in_rdy: 1'b0, issue: 1'b0, scale: 1'b0, round: 1'b0, fbmul: 1'b0,
			commit: 1'b0, cond: COND_PIPE_IDLE, jmp: ST_SCALE},
		'{in_rdy: 1'b0, issue: 1'b0, scale: 1'b1, round: 1'b0, fbmul: 1'b0,
			commit: 1'b0, cond: COND_ALWAYS, jmp: ST_ROUND},
		'{in_rdy: 1'b0, issue: 1'b0, scale: 1'b0, round: 1'b1, fbmul: 1'b0,
			commit: 1'b0, cond: COND_ALWAYS, jmp: ST_FBMUL},
		'{in_rdy: 1'b0, issue: 1'b0, scale: 1'b0, round: 1'b0, fbmul: 1'b1,
			commit: 1'b0, cond: COND_ALWAYS, jmp: ST_COMMIT},
		'{in_rdy: 1'b0, issue: 1'b0, scale: 1'b0, round: 1'b0, fbmul: 1'b0,
			commit: 1'b1, cond: COND_OUT_FREE, jmp: ST_WAIT_IN},
		'{in_rdy: 1'b0, issue: 1'b0, scale: 1'b0, round: 1'b0, fbmul: 1'b0,
			commit: 1'b0, cond: COND_ALWAYS, jmp: ST_WAIT_IN}
	};

	step_t                           step_q;
	ucode_t                          word;
	logic                            cond_ok;
	logic                            accept;
	logic [mfcn_pkg::TAP_W-1:0]      tap_q;
	logic [mfcn_pkg::ADDR_W-1:0]     wp_q;
	logic                            wrapped_q;

	assign word = UCODE[step_q];

	// Evaluate the branch condition of the current word
	always_comb begin
		unique case (word.cond)
			COND_ALWAYS:    cond_ok = 1'b1;
			COND_IN_VALID:  cond_ok = stat.in_valid;
			COND_LAST_TAP:  cond_ok = (tap_q == mfcn_pkg::TAP_W'(mfcn_pkg::TAP_COUNT));
			COND_PIPE_IDLE: cond_ok = stat.pipe_idle;
			COND_OUT_FREE:  cond_ok = stat.out_free;
			default:        cond_ok = 1'b0;
		endcase
	end

	assign in_ready = word.in_rdy;
	assign accept   = word.in_rdy & stat.in_valid;

	// Drive the datapath
	always_comb begin
		ctl.load    = accept;
		ctl.issue   = word.issue;
		ctl.scale   = word.scale;
		ctl.round   = word.round;
		ctl.fbmul   = word.fbmul;
		ctl.commit  = word.commit & cond_ok;
		ctl.tap     = tap_q;
		ctl.wp      = wp_q;
		ctl.wrapped = wrapped_q;
	end

	// Advance or hold the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT_IN;
		end else if (cond_ok) begin
			step_q <= word.jmp;
		end
	end

	// Count taps: restart at one per beat, advance per issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (accept) begin
			tap_q <= mfcn_pkg::TAP_W'(1);
		end else if (word.issue) begin
			tap_q <= tap_q + mfcn_pkg::TAP_W'(1);
		end
	end

	// Advance the write position after each committed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (ctl.commit) begin
			if (wp_q == mfcn_pkg::ADDR_W'(mfcn_pkg::STORE_DEPTH - 1)) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + mfcn_pkg::ADDR_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/mfcn_tapgen.sv]
// Tap address generator: per tap, left offset t*left_period and right offset
// t*floor(right_period/t), turned into memory addresses behind the write
// position. Depends on mfcn_pkg (reciprocal table, tap_t, ctl_t).
`default_nettype none

module mfcn_tapgen (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mfcn_pkg::ctl_t                 ctl,
	input  wire logic [mfcn_pkg::PERIOD_W-1:0]  left_period,
	input  wire logic [mfcn_pkg::PERIOD_W-1:0]  right_period,
	output mfcn_pkg::tap_t                      tap_l,
	output mfcn_pkg::tap_t                      tap_r,
	output logic                                busy
);

	localparam int RLO_W  = mfcn_pkg::PERIOD_W + mfcn_pkg::RCP_LO_W;
	localparam int RHI_W  = mfcn_pkg::PERIOD_W + mfcn_pkg::RCP_HI_W;
	localparam int RSUM_W = mfcn_pkg::PERIOD_W + mfcn_pkg::RCP_W;
	localparam int OFFX_W = mfcn_pkg::ADDR_W + mfcn_pkg::PERIOD_W + mfcn_pkg::TAP_W;

	logic [mfcn_pkg::RCP_W-1:0]     rcp;
	logic                           v_s1, v_s2, v_s3, v_s4;
	logic [mfcn_pkg::TAP_W-1:0]     t_s1, t_s2, t_s3, t_s4;
	logic [RLO_W-1:0]               rlo_s1;
	logic [RHI_W-1:0]               rhi_s1;
	logic [RSUM_W-1:0]              rsum;
	logic [mfcn_pkg::PERIOD_W-1:0]  q_s2;
	logic [OFFX_W-1:0]              offl_full, offr_full;
	logic [mfcn_pkg::ADDR_W-1:0]    offl_s3, offr_s3;
	logic [mfcn_pkg::ADDR_W-1:0]    addr_l, addr_r;
	logic [mfcn_pkg::ADDR_W-1:0]    addr_l_s4, addr_r_s4;
	logic                           hit_l_s4, hit_r_s4;

	assign rcp = mfcn_pkg::RCP_TABLE[mfcn_pkg::RCP_IDX_W'(ctl.tap - mfcn_pkg::TAP_W'(1))];

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: right period times reciprocal, split in two partial products
	always_ff @(posedge clk) begin
		t_s1   <= ctl.tap;
		rlo_s1 <= RLO_W'(right_period) * RLO_W'(rcp[mfcn_pkg::RCP_LO_W-1:0]);
		rhi_s1 <= RHI_W'(right_period) * RHI_W'(rcp[mfcn_pkg::RCP_W-1:mfcn_pkg::RCP_LO_W]);
	end

	// Stage 2: combine partials, keep floor(right_period / t)
	assign rsum = (RSUM_W'(rhi_s1) << mfcn_pkg::RCP_LO_W) + RSUM_W'(rlo_s1);

	always_ff @(posedge clk) begin
		t_s2 <= t_s1;
		q_s2 <= rsum[mfcn_pkg::RCP_SHIFT +: mfcn_pkg::PERIOD_W];
	end

	// Stage 3: offsets modulo the memory depth
	assign offl_full = OFFX_W'(t_s2) * OFFX_W'(left_period);
	assign offr_full = OFFX_W'(t_s2) * OFFX_W'(q_s2);

	always_ff @(posedge clk) begin
		t_s3    <= t_s2;
		offl_s3 <= offl_full[mfcn_pkg::ADDR_W-1:0];
		offr_s3 <= offr_full[mfcn_pkg::ADDR_W-1:0];
	end

	// Stage 4: addresses behind the write position, flag entries never written
	assign addr_l = ctl.wp - offl_s3;
	assign addr_r = ctl.wp - offr_s3;

	always_ff @(posedge clk) begin
		addr_l_s4 <= addr_l;
		hit_l_s4  <= ctl.wrapped | (addr_l < ctl.wp);
		addr_r_s4 <= addr_r;
		hit_r_s4  <= ctl.wrapped | (addr_r < ctl.wp);
		t_s4      <= t_s3;
	end

	// Present the read requests
	always_comb begin
		tap_l.v    = v_s4;
		tap_l.addr = addr_l_s4;
		tap_l.hit  = hit_l_s4;
		tap_l.t    = t_s4;
		tap_r.v    = v_s4;
		tap_r.addr = addr_r_s4;
		tap_r.hit  = hit_r_s4;
		tap_r.t    = t_s4;
	end

	assign busy = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

`default_nettype wire

[rtl/mfcn_lane.sv]
// One channel of the comb: delay memory, weighted tap pipeline with division
// by the tap number, accumulator, output scaling, saturation and feedback.
// Depends on mfcn_pkg (ctl_t, tap_t, reciprocal table).
`default_nettype none

module mfcn_lane (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mfcn_pkg::ctl_t                       ctl,
	input  wire mfcn_pkg::tap_t                       tap,
	input  wire logic signed [mfcn_pkg::SAMPLE_W-1:0] noise,
	input  wire logic signed [mfcn_pkg::GAIN_W-1:0]   harmonic_gain,
	input  wire logic signed [mfcn_pkg::GAIN_W-1:0]   output_gain,
	output logic signed [mfcn_pkg::SAMPLE_W-1:0]      y,
	output logic                                      busy
);

	localparam int PROD_W      = 2 * mfcn_pkg::SAMPLE_W;
	localparam int MAG_W       = PROD_W - 1;
	localparam int PLO_W       = MAG_W + mfcn_pkg::RCP_LO_W;
	localparam int PHI_W       = MAG_W + mfcn_pkg::RCP_HI_W;
	localparam int QSUM_W      = MAG_W + mfcn_pkg::RCP_W;
	localparam int ACC_W       = 36;
	localparam int NOISE_SHIFT = 12;
	localparam int SC_W        = ACC_W + mfcn_pkg::GAIN_W;
	localparam int OUT_SHIFT   = 24;
	localparam int ROUND_BIAS  = 1 << (OUT_SHIFT - 1);
	localparam int FBP_W       = 2 * mfcn_pkg::SAMPLE_W;
	localparam int FB_SHIFT    = 15;
	localparam int FB_BIAS     = 1 << (FB_SHIFT - 1);

	localparam logic signed [SC_W-1:0] SC_MAX = SC_W'(32767);
	localparam logic signed [SC_W-1:0] SC_MIN = -SC_W'(32768);
	localparam logic signed [mfcn_pkg::SAMPLE_W-1:0] FB_GAIN = 16'sd26214;

	logic signed [mfcn_pkg::SAMPLE_W-1:0] mem_q [mfcn_pkg::STORE_DEPTH];

	logic                                 v_s5, v_s6, v_s7, v_s8, v_s9;
	logic                                 hit_s5;
	logic [mfcn_pkg::TAP_W-1:0]           t_s5, t_s6;
	logic signed [mfcn_pkg::SAMPLE_W-1:0] rd_s5;
	logic signed [mfcn_pkg::SAMPLE_W-1:0] smp;
	logic signed [PROD_W-1:0]             prod_s6;
	logic                                 neg_s7, neg_s8, neg_s9;
	logic [MAG_W-1:0]                     mag_s7;
	logic [mfcn_pkg::RCP_W-1:0]           rcp_s7;
	logic [PLO_W-1:0]                     plo_s8;
	logic [PHI_W-1:0]                     phi_s8;
	logic [QSUM_W-1:0]                    qsum;
	logic [MAG_W-1:0]                     quot_s9;
	logic signed [ACC_W-1:0]              acc_q;
	logic signed [SC_W-1:0]               sc_q;
	logic signed [SC_W-1:0]               rnd_sh;
	logic signed [mfcn_pkg::SAMPLE_W-1:0] y_q;
	logic signed [FBP_W-1:0]              fbp_q;
	logic signed [FBP_W-1:0]              fb_sum;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s5 <= tap.v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign fb_sum = (fbp_q + FBP_W'(FB_BIAS)) >>> FB_SHIFT;

	// Delay memory: feedback write at commit, registered tap read
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			mem_q[ctl.wp] <= fb_sum[mfcn_pkg::SAMPLE_W-1:0];
		end
		rd_s5  <= mem_q[tap.addr];
		hit_s5 <= tap.hit;
		t_s5   <= tap.t;
	end

	// Unwritten entries read as zero
	assign smp = hit_s5 ? rd_s5 : '0;

	// Weighted tap, then sign and magnitude with the reciprocal of t
	always_ff @(posedge clk) begin
		prod_s6 <= PROD_W'(harmonic_gain) * PROD_W'(smp);
		t_s6    <= t_s5;
		neg_s7  <= prod_s6[PROD_W-1];
		mag_s7  <= prod_s6[PROD_W-1] ? MAG_W'(-prod_s6) : MAG_W'(prod_s6);
		rcp_s7  <= mfcn_pkg::RCP_TABLE[mfcn_pkg::RCP_IDX_W'(t_s6 - mfcn_pkg::TAP_W'(1))];
	end

	// Magnitude times reciprocal, as two partial products
	always_ff @(posedge clk) begin
		neg_s8 <= neg_s7;
		plo_s8 <= PLO_W'(mag_s7) * PLO_W'(rcp_s7[mfcn_pkg::RCP_LO_W-1:0]);
		phi_s8 <= PHI_W'(mag_s7) * PHI_W'(rcp_s7[mfcn_pkg::RCP_W-1:mfcn_pkg::RCP_LO_W]);
	end

	// Quotient truncated toward zero
	assign qsum = (QSUM_W'(phi_s8) << mfcn_pkg::RCP_LO_W) + QSUM_W'(plo_s8);

	always_ff @(posedge clk) begin
		neg_s9  <= neg_s8;
		quot_s9 <= qsum[mfcn_pkg::RCP_SHIFT +: MAG_W];
	end

	// Preload with the excitation, then add or subtract each tap term
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= ACC_W'(noise) <<< NOISE_SHIFT;
		end else if (v_s9) begin
			acc_q <= neg_s9 ? acc_q - ACC_W'(quot_s9) : acc_q + ACC_W'(quot_s9);
		end
	end

	// Scale, round half up, saturate, then form the feedback product
	assign rnd_sh = (sc_q + SC_W'(ROUND_BIAS)) >>> OUT_SHIFT;

	always_ff @(posedge clk) begin
		if (ctl.scale) begin
			sc_q <= SC_W'(acc_q) * SC_W'(output_gain);
		end
		if (ctl.round) begin
			if (rnd_sh > SC_MAX) begin
				y_q <= SC_MAX[mfcn_pkg::SAMPLE_W-1:0];
			end else if (rnd_sh < SC_MIN) begin
				y_q <= SC_MIN[mfcn_pkg::SAMPLE_W-1:0];
			end else begin
				y_q <= rnd_sh[mfcn_pkg::SAMPLE_W-1:0];
			end
		end
		if (ctl.fbmul) begin
			fbp_q <= FBP_W'(y_q) * FBP_W'(FB_GAIN);
		end
	end

	assign y    = y_q;
	assign busy = v_s5 | v_s6 | v_s7 | v_s8 | v_s9;

endmodule

`default_nettype wire

[rtl/multitap_feedback_comb_noise.sv]
// Stereo multitap feedback comb resonator.
//
// Channels: excite carries one noise sample per side (valid/ready); result
// carries one saturated Q1.15 sample per side. A beat is taken when valid
// and ready are both high. Configuration is a write port (cfg_we, cfg_index,
// cfg_data): left_period, right_period, harmonic_gain, output_gain; write it
// only while no beat is in flight.
//
// Timing: a beat issues its TAP_COUNT taps, one tap per cycle through the
// single read port of each delay memory, drains the address and weighting
// pipeline, then runs the scale, round, feedback multiply and commit steps
// and returns to the wait step. The result sits in an output register, so
// the next excitation beat is taken while it waits; if it is still not
// taken when the next result is ready, the commit step waits.
//
// Reset: registers take their defaults, write position is zero. The delay
// memories are not swept: an entry at or after the write position before the
// first wrap reads as zero, so the block is ready right after reset.
`default_nettype none

module multitap_feedback_comb_noise (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	mfcn_noise_if.sink                               excite,
	mfcn_result_if.source                            result,
	input  wire logic                                cfg_we,
	input  wire logic [mfcn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mfcn_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [mfcn_pkg::PERIOD_W-1:0]        left_period_q;
	logic [mfcn_pkg::PERIOD_W-1:0]        right_period_q;
	logic signed [mfcn_pkg::GAIN_W-1:0]   harmonic_gain_q;
	logic signed [mfcn_pkg::GAIN_W-1:0]   output_gain_q;

	mfcn_pkg::ctl_t                       ctl;
	mfcn_pkg::seq_stat_t                  stat;
	mfcn_pkg::tap_t                       tap_l, tap_r;
	logic                                 tg_busy, busy_l, busy_r;
	logic                                 in_ready;
	logic signed [mfcn_pkg::SAMPLE_W-1:0] y_l, y_r;

	logic                                 res_valid_q;
	logic signed [mfcn_pkg::SAMPLE_W-1:0] res_l_q, res_r_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_period_q   <= mfcn_pkg::RST_LEFT_PERIOD;
			right_period_q  <= mfcn_pkg::RST_RIGHT_PERIOD;
			harmonic_gain_q <= mfcn_pkg::RST_HARMONIC_GAIN;
			output_gain_q   <= mfcn_pkg::RST_OUTPUT_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfcn_pkg::CFG_LEFT_PERIOD:   left_period_q   <= cfg_data;
				mfcn_pkg::CFG_RIGHT_PERIOD:  right_period_q  <= cfg_data;
				mfcn_pkg::CFG_HARMONIC_GAIN: harmonic_gain_q <= cfg_data;
				mfcn_pkg::CFG_OUTPUT_GAIN:   output_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer status
	always_comb begin
		stat.in_valid  = excite.valid;
		stat.out_free  = ~res_valid_q | result.ready;
		stat.pipe_idle = ~(tg_busy | busy_l | busy_r);
	end

	mfcn_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	mfcn_tapgen u_tapgen (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.left_period  (left_period_q),
		.right_period (right_period_q),
		.tap_l        (tap_l),
		.tap_r        (tap_r),
		.busy         (tg_busy)
	);

	mfcn_lane u_lane_l (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.tap           (tap_l),
		.noise         (excite.noise_left),
		.harmonic_gain (harmonic_gain_q),
		.output_gain   (output_gain_q),
		.y             (y_l),
		.busy          (busy_l)
	);

	mfcn_lane u_lane_r (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.tap           (tap_r),
		.noise         (excite.noise_right),
		.harmonic_gain (harmonic_gain_q),
		.output_gain   (output_gain_q),
		.y             (y_r),
		.busy          (busy_r)
	);

	assign excite.ready = in_ready;

	// Output register: load at commit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			res_l_q <= y_l;
			res_r_q <= y_r;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.out_left  = res_l_q;
	assign result.out_right = res_r_q;

endmodule

`default_nettype wire

[rtl/mfcn_checker.sv]
// Port-level checks for the comb block, attached to the top level by bind.
// Depends on mfcn_pkg for the sample width.
`default_nettype none

module mfcn_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire logic signed [mfcn_pkg::SAMPLE_W-1:0] out_left,
	input  wire logic signed [mfcn_pkg::SAMPLE_W-1:0] out_right
);

	// A taken excitation beat closes the input until the result is done
	a_accept_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("excite ready stayed high after a beat was taken");

	// A new result only comes out of a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while input side was idle");

	// Stalled result stays valid
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// Stalled result keeps its data
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_left) && $stable(out_right))
		else $error("result data changed while stalled");

endmodule

bind multitap_feedback_comb_noise mfcn_checker u_mfcn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (excite.valid),
	.in_ready  (excite.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_left  (result.out_left),
	.out_right (result.out_right)
);

`default_nettype wire

[tb/sv/comb_checker.sv]
// Checker for the stereo multitap comb: watches the excitation, result and
// configuration ports, predicts each result pair and compares it.
// Depends on mfcn_pkg and the channel interfaces in mfcn_ifs.sv.
`timescale 1ns / 1ps

module comb_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	mfcn_noise_if.monitor                         excite,
	mfcn_result_if.monitor                        result,
	input  logic                                  cfg_we,
	input  logic [mfcn_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mfcn_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                    outstanding,
	output int                                    fails
);
	import mfcn_pkg::*;

	// 0.8 in Q0.15 for the value fed back into the delay line
	localparam logic signed [63:0] FEEDBACK_GAIN = 64'sd26214;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} sample_pair_t;

	// Shadow copy of the block's state and registers
	logic signed [SAMPLE_W-1:0] left_line  [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0] right_line [STORE_DEPTH];
	logic [ADDR_W-1:0]          head;
	logic [PERIOD_W-1:0]        left_period;
	logic [PERIOD_W-1:0]        right_period;
	logic signed [GAIN_W-1:0]   harmonic_gain;
	logic signed [GAIN_W-1:0]   output_gain;

	sample_pair_t resonator_out [$];

	// One channel of the comb: excitation plus weighted taps, scaled,
	// rounded and saturated to full scale
	function automatic logic signed [SAMPLE_W-1:0] comb_channel(
		input bit right_side, input logic signed [SAMPLE_W-1:0] noise);
		logic signed [63:0] acc;
		logic signed [63:0] prod;
		logic signed [63:0] y;
		int span;
		logic [ADDR_W-1:0] idx;
		acc = noise;
		acc = acc * 64'sd4096;
		for (int t = 1; t <= TAP_COUNT; t++) begin
			if (right_side)
				span = t * (int'(right_period) / t);
			else
				span = t * int'(left_period);
			idx = head - span[ADDR_W-1:0];
			prod = right_side ? right_line[idx] : left_line[idx];
			prod = prod * harmonic_gain;
			// signed division truncates toward zero
			acc = acc + prod / t;
		end
		y = acc * output_gain;
		y = (y + (64'sd1 <<< 23)) >>> 24;
		if (y > 64'sd32767)
			y = 64'sd32767;
		else if (y < -64'sd32768)
			y = -64'sd32768;
		return y[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] echo_of(
		input logic signed [SAMPLE_W-1:0] y);
		logic signed [63:0] v;
		v = y;
		v = (v * FEEDBACK_GAIN + 64'sd16384) >>> 15;
		return v[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		sample_pair_t want;
		sample_pair_t got;
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				left_line[i]  = '0;
				right_line[i] = '0;
			end
			head          = '0;
			left_period   = RST_LEFT_PERIOD;
			right_period  = RST_RIGHT_PERIOD;
			harmonic_gain = RST_HARMONIC_GAIN;
			output_gain   = RST_OUTPUT_GAIN;
			resonator_out.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEFT_PERIOD:   left_period   = cfg_data;
					CFG_RIGHT_PERIOD:  right_period  = cfg_data;
					CFG_HARMONIC_GAIN: harmonic_gain = cfg_data;
					CFG_OUTPUT_GAIN:   output_gain   = cfg_data;
					default: ;
				endcase
			end

			// compare a result beat with the oldest prediction
			if (result.valid && result.ready) begin
				got.left  = result.out_left;
				got.right = result.out_right;
				if (resonator_out.size() == 0) begin
					if (fails < MAX_REPORTS)
						$display("%0t: result beat with nothing predicted: L=%0d R=%0d",
							$realtime, got.left, got.right);
					fails++;
				end else begin
					want = resonator_out.pop_front();
					if (got.left !== want.left) begin
						if (fails < MAX_REPORTS)
							$display("%0t: out_left expected %0d got %0d",
								$realtime, want.left, got.left);
						fails++;
					end
					if (got.right !== want.right) begin
						if (fails < MAX_REPORTS)
							$display("%0t: out_right expected %0d got %0d",
								$realtime, want.right, got.right);
						fails++;
					end
				end
			end

			// predict the result of an excitation beat, then feed back and advance
			if (excite.valid && excite.ready) begin
				want.left  = comb_channel(1'b0, excite.noise_left);
				want.right = comb_channel(1'b1, excite.noise_right);
				resonator_out.push_back(want);
				left_line[head]  = echo_of(want.left);
				right_line[head] = echo_of(want.right);
				head = head + 1'b1;
			end

			outstanding <= resonator_out.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Top of the comb resonator testbench: clock, reset, excitation and result
// pacing, register phases and the verdict. Depends on mfcn_pkg, mfcn_ifs.sv,
// the block itself and comb_checker.
`timescale 1ns / 1ps

module tb;
	import mfcn_pkg::*;

	localparam int RANDOM_PHASES    = 10;
	localparam int ITEMS_PER_PHASE  = 150;
	localparam int IDLE_PERCENT     = 6;
	localparam longint LIMIT_CYCLES = 600_000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int outstanding;
	int fails;

	mfcn_noise_if  excite_ch ();
	mfcn_result_if result_ch ();

	multitap_feedback_comb_noise dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.excite    (excite_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	comb_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.excite      (excite_ch),
		.result      (result_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fails       (fails)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Give up on a hung run
	initial begin
		#(LIMIT_CYCLES * 12);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls, one long hold-off that backs the block up,
	// and a long stretch that always accepts
	initial begin : drain
		int cycle;
		cycle = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle >= 3000 && cycle < 3400)
				result_ch.ready <= 1'b0;
			else if (cycle >= 10000 && cycle < 20000)
				result_ch.ready <= 1'b1;
			else
				result_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Offer one excitation beat and hold it until taken
	task automatic send_excitation(input logic [SAMPLE_W-1:0] left,
		input logic [SAMPLE_W-1:0] right, input bit steady);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				excite_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		excite_ch.valid       <= 1'b1;
		excite_ch.noise_left  <= left;
		excite_ch.noise_right <= right;
		@(posedge clk);
		while (!excite_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering and wait for every predicted result to drain
	task automatic settle();
		excite_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [PERIOD_W-1:0] lp,
		input logic [PERIOD_W-1:0] rp, input logic [GAIN_W-1:0] hg,
		input logic [GAIN_W-1:0] og);
		settle();
		write_reg(CFG_LEFT_PERIOD, lp);
		write_reg(CFG_RIGHT_PERIOD, rp);
		write_reg(CFG_HARMONIC_GAIN, hg);
		write_reg(CFG_OUTPUT_GAIN, og);
		cfg_we <= 1'b0;
	endtask

	// Excitation: extremes, full-range noise and quiet noise
	function automatic logic [SAMPLE_W-1:0] pick_noise();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3, 4, 5: return SAMPLE_W'($urandom);
			default: return SAMPLE_W'($urandom_range(8191) - 4096);
		endcase
	endfunction

	// Mostly short periods so taps land on written history
	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(7))
			0: return '0;
			1: return 16'hffff;
			2: return PERIOD_W'($urandom);
			3: return PERIOD_W'($urandom_range(4, 1));
			default: return PERIOD_W'($urandom_range(120, 1));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_tap_gain();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return GAIN_W'($urandom);
			3: return '0;
			default: return GAIN_W'($urandom_range(6000) - 3000);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_out_gain();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return GAIN_W'($urandom);
			3: return '0;
			default: begin
				g = GAIN_W'($urandom_range(6144, 2048));
				return $urandom_range(1) ? g : -g;
			end
		endcase
	endfunction

	initial begin : stimulus
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		excite_ch.valid       <= 1'b0;
		excite_ch.noise_left  <= '0;
		excite_ch.noise_right <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: field extremes and alternating bit patterns
		send_excitation(16'h7fff, 16'h8000, 1'b0);
		send_excitation(16'h8000, 16'h7fff, 1'b0);
		send_excitation(16'h0000, 16'hffff, 1'b0);
		send_excitation(16'h0001, 16'h0000, 1'b0);
		send_excitation(16'h5555, 16'haaaa, 1'b0);
		send_excitation(16'haaaa, 16'h5555, 1'b0);

		// Zero period with the largest gains: tap reads the entry about to be
		// overwritten, output drives into positive and negative saturation
		load_settings(16'd0, 16'd0, 16'h7fff, 16'h7fff);
		send_excitation(16'h7fff, 16'h7fff, 1'b0);
		send_excitation(16'h4000, 16'h2000, 1'b0);
		send_excitation(16'h0001, 16'hffff, 1'b0);
		send_excitation(16'h8000, 16'h8000, 1'b0);

		// Most negative gains, one-sample left delay, longest right delay
		load_settings(16'd1, 16'hffff, 16'h8000, 16'h8000);
		send_excitation(16'h7fff, 16'h8000, 1'b0);
		send_excitation(16'h1234, 16'hedcb, 1'b0);
		send_excitation(16'h8000, 16'h7fff, 1'b0);
		send_excitation(16'h0000, 16'h0000, 1'b0);

		// Offsets that wrap around the delay line
		load_settings(16'hffff, 16'h8001, 16'h1000, 16'h1000);
		send_excitation(16'h7fff, 16'h7fff, 1'b0);
		send_excitation(16'h8000, 16'h8000, 1'b0);
		send_excitation(16'h3000, 16'hd000, 1'b0);

		// Short periods, zero output gain
		load_settings(16'd2, 16'd3, 16'h0800, 16'h0000);
		send_excitation(16'h7fff, 16'h8000, 1'b0);
		send_excitation(16'h2222, 16'hdddd, 1'b0);
		send_excitation(16'h8000, 16'h7fff, 1'b0);

		// Random phases, each under fresh settings
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			load_settings(pick_period(), pick_period(), pick_tap_gain(),
				pick_out_gain());
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// pause once until every result is back
				if (phase == 4 && i == ITEMS_PER_PHASE / 2)
					settle();
				send_excitation(pick_noise(), pick_noise(), phase == 2 || phase == 3);
			end
		end

		// Drain and give the verdict
		excite_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (60) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/mfcn_pkg.sv
rtl/mfcn_ifs.sv
rtl/mfcn_seq.sv
rtl/mfcn_tapgen.sv
rtl/mfcn_lane.sv
rtl/multitap_feedback_comb_noise.sv
rtl/mfcn_checker.sv
tb/sv/comb_checker.sv
tb/sv/tb.sv
